FILE: sv/jsu_pkg.sv
package jsu_pkg;

    localparam int MaxResults = 4;
    localparam int CountWidth = $clog2(MaxResults + 1);
    localparam int IndexWidth = $clog2(MaxResults);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_NO_QUOTE     = 4'd1,
        ERR_CONTROL      = 4'd2,
        ERR_ESC_CUT      = 4'd3,
        ERR_BAD_ESC      = 4'd4,
        ERR_HEX_CUT      = 4'd5,
        ERR_BAD_HEX      = 4'd6,
        ERR_NO_LOW       = 4'd7,
        ERR_BAD_LOW      = 4'd8,
        ERR_LONE_LOW     = 4'd9,
        ERR_UNTERMINATED = 4'd10
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        err_t       error_code;
        logic       last_of_run;
    } out_t;

    // All results caused by one input item, in order.
    typedef struct packed {
        out_t [MaxResults-1:0]  res;
        logic [CountWidth-1:0]  count;
    } bundle_t;

endpackage

FILE: sv/json_string_unescaper.sv
// Decodes the bytes of one quoted JSON string literal, opening quote first,
// into its UTF-8 bytes, followed by a done or error status. Each item passes
// an input register, is decoded combinationally into a bundle of zero to four
// results, and the bundle is registered and sent out one result per cycle
// while m_ready is high, so plain text runs at one byte per cycle without
// back-pressure. A unicode escape can expand to four bytes, all sent through
// the single result port; the next item is taken as the last result of a
// bundle is accepted. After a status result or a byte marked last the block
// waits for a new opening quote.
module json_string_unescaper (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  jsu_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output jsu_pkg::out_t m_data
);
    import jsu_pkg::*;

    in_t     in_reg;
    logic    in_valid_reg;
    logic    free_next;
    logic    advance;
    bundle_t bundle;

    assign advance = in_valid_reg && free_next;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_reg),
        .advance (advance),
        .bundle  (bundle)
    );

    jsu_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && bundle.count != '0),
        .bundle    (bundle),
        .free_next (free_next),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A held input item stays put until the decoder takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("input item lost while stalled");

endmodule

FILE: sv/jsu_decode.sv
module jsu_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  jsu_pkg::in_t     item,
    input  logic             advance,
    output jsu_pkg::bundle_t bundle
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX1,
        MODE_WANT_BS,
        MODE_WANT_U,
        MODE_HEX2
    } mode_t;

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChB = 8'h62;
    localparam logic [7:0] ChF = 8'h66;
    localparam logic [7:0] ChN = 8'h6E;
    localparam logic [7:0] ChR = 8'h72;
    localparam logic [7:0] ChT = 8'h74;
    localparam logic [7:0] ChU = 8'h75;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } utf8_t;

    function automatic utf8_t encode_utf8(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp <= 21'h7F) begin
            r.bytes[0] = cp[7:0];
            r.n = 3'd1;
        end else if (cp <= 21'h7FF) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.n = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.n = 3'd3;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.n = 3'd4;
        end
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [11:0] acc_reg, acc_next;
    logic [9:0]  high_reg, high_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        bad_reg, bad_next;

    logic [7:0]  b;
    logic [3:0]  digit;
    logic        digit_ok;
    logic [15:0] quad;
    logic [20:0] cp;
    utf8_t       enc;
    logic [3:0][7:0] bytes;
    logic [2:0]  nb;
    err_t        err;
    logic        done;

    assign b = item.data_byte;

    always_comb begin
        digit_ok = 1'b1;
        digit = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            digit = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            digit = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            digit = 4'(b - 8'h37);
        end else begin
            digit_ok = 1'b0;
        end
    end

    // Only the low surrogate case takes the supplementary-plane path; the sum
    // (high + 0x40) << 10 carries the 0x10000 offset.
    assign quad = {acc_reg, digit};
    assign cp = (mode_reg == MODE_HEX2) ? {11'({1'b0, high_reg} + 11'd64), quad[9:0]}
                                        : {5'd0, quad};
    assign enc = encode_utf8(cp);

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        high_next = high_reg;
        cnt_next  = cnt_reg;
        bad_next  = bad_reg;
        bytes     = '0;
        nb        = 3'd0;
        err       = ERR_NONE;
        done      = 1'b0;

        unique case (mode_reg)
            MODE_IDLE: begin
                if (b == ChQuote) mode_next = MODE_STR;
                else err = ERR_NO_QUOTE;
            end
            MODE_STR: begin
                priority if (b == ChQuote) begin
                    done = 1'b1;
                end else if (b < 8'h20) begin
                    err = ERR_CONTROL;
                end else if (b == ChBslash) begin
                    mode_next = MODE_ESC;
                end else begin
                    bytes[0] = b;
                    nb = 3'd1;
                end
            end
            MODE_ESC: begin
                mode_next = MODE_STR;
                nb = 3'd1;
                unique case (b)
                    ChQuote, ChBslash, ChSlash: bytes[0] = b;
                    ChB: bytes[0] = 8'h08;
                    ChF: bytes[0] = 8'h0C;
                    ChN: bytes[0] = 8'h0A;
                    ChR: bytes[0] = 8'h0D;
                    ChT: bytes[0] = 8'h09;
                    ChU: begin
                        nb = 3'd0;
                        mode_next = MODE_HEX1;
                        acc_next = '0;
                        cnt_next = '0;
                        bad_next = 1'b0;
                    end
                    default: begin
                        nb = 3'd0;
                        err = ERR_BAD_ESC;
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2: begin
                acc_next = quad[11:0];
                cnt_next = cnt_reg + 2'd1;
                bad_next = bad_reg | ~digit_ok;
                if (cnt_reg == 2'd3) begin
                    if (mode_reg == MODE_HEX1) begin
                        priority if (bad_next) begin
                            err = ERR_BAD_HEX;
                        end else if (quad[15:10] == 6'b110111) begin
                            err = ERR_LONE_LOW;
                        end else if (quad[15:10] == 6'b110110) begin
                            high_next = quad[9:0];
                            mode_next = MODE_WANT_BS;
                        end else begin
                            bytes = enc.bytes;
                            nb = enc.n;
                            mode_next = MODE_STR;
                        end
                    end else begin
                        if (bad_next || quad[15:10] != 6'b110111) begin
                            err = ERR_BAD_LOW;
                        end else begin
                            bytes = enc.bytes;
                            nb = enc.n;
                            mode_next = MODE_STR;
                        end
                    end
                end
            end
            MODE_WANT_BS: begin
                if (b == ChBslash) mode_next = MODE_WANT_U;
                else err = ERR_NO_LOW;
            end
            MODE_WANT_U: begin
                if (b == ChU) begin
                    mode_next = MODE_HEX2;
                    acc_next = '0;
                    cnt_next = '0;
                    bad_next = 1'b0;
                end else begin
                    err = ERR_NO_LOW;
                end
            end
            default: err = ERR_NO_QUOTE;
        endcase

        // The input ends inside the string: the whole string is void, so only
        // the error for the position reached is reported.
        if (err == ERR_NONE && !done && item.is_last) begin
            nb = 3'd0;
            unique case (mode_next)
                MODE_ESC: err = ERR_ESC_CUT;
                MODE_HEX1: err = ERR_HEX_CUT;
                MODE_WANT_BS, MODE_WANT_U: err = ERR_NO_LOW;
                MODE_HEX2: err = ERR_BAD_LOW;
                default: err = ERR_UNTERMINATED;
            endcase
        end

        if (err != ERR_NONE || done) begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            high_next = '0;
            cnt_next  = '0;
            bad_next  = 1'b0;
        end
    end

    always_comb begin
        bundle = '0;
        if (err != ERR_NONE) begin
            bundle.res[0].kind = KIND_ERROR;
            bundle.res[0].error_code = err;
            bundle.count = CountWidth'(1);
        end else if (done) begin
            bundle.res[0].kind = KIND_DONE;
            bundle.count = CountWidth'(1);
        end else begin
            for (int i = 0; i < MaxResults; i++) begin
                bundle.res[i].out_byte = bytes[i];
                bundle.res[i].kind = KIND_BYTE;
                bundle.res[i].error_code = ERR_NONE;
            end
            bundle.count = CountWidth'(nb);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            high_reg <= '0;
            cnt_reg  <= '0;
            bad_reg  <= 1'b0;
        end else if (advance) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            high_reg <= high_next;
            cnt_reg  <= cnt_next;
            bad_reg  <= bad_next;
        end
    end

    // A final byte always leaves the decoder waiting for a new opening quote.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.is_last |=> mode_reg == MODE_IDLE)
        else $error("decoder not idle after final byte");

endmodule

FILE: sv/jsu_emit.sv
module jsu_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  jsu_pkg::bundle_t bundle,
    output logic             free_next,
    output logic             m_valid,
    input  logic             m_ready,
    output jsu_pkg::out_t    m_data
);
    import jsu_pkg::*;

    bundle_t               bundle_reg;
    logic [CountWidth-1:0] count_reg;
    logic [IndexWidth-1:0] idx_reg;
    logic                  at_last;

    assign m_valid = (count_reg != '0);
    assign at_last = ({1'b0, idx_reg} == CountWidth'(count_reg - CountWidth'(1)));
    assign free_next = !m_valid || (m_ready && at_last);

    always_comb begin
        m_data = bundle_reg.res[idx_reg];
        m_data.last_of_run = at_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else if (load) begin
            count_reg <= bundle.count;
            idx_reg   <= '0;
        end else if (m_valid && m_ready) begin
            if (at_last) begin
                count_reg <= '0;
                idx_reg   <= '0;
            end else begin
                idx_reg <= idx_reg + IndexWidth'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> count_reg <= CountWidth'(MaxResults) && {1'b0, idx_reg} < count_reg)
        else $error("result index beyond bundle");

    // Status results close a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_BYTE |-> m_data.last_of_run)
        else $error("status result not last of run");

endmodule
